// ===== hdl/pwpbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pwpbf_pkg: shared types and constants for the panel byte formatter
// Command codes, byte slot codes and the held item record.
// ----------------------------------------------------------------------------
`default_nettype none

package pwpbf_pkg;

  localparam int unsigned CoordWidth = 10;
  localparam int unsigned InCoordW   = 10;
  localparam logic [15:0] CoordMask  = 16'((32'd1 << CoordWidth) - 32'd1);

  localparam logic [7:0] CmdInvOn   = 8'h21;
  localparam logic [7:0] CmdInvOff  = 8'h20;
  localparam logic [7:0] CmdAccess  = 8'h36;
  localparam logic [7:0] CmdColumn  = 8'h2A;
  localparam logic [7:0] CmdRow     = 8'h2B;
  localparam logic [7:0] CmdWrite   = 8'h2C;
  localparam logic [7:0] AccessBase = 8'hE8;
  localparam logic [7:0] AccessFlip = 8'h28;
  localparam logic [7:0] AccessBgr  = 8'h08;

  typedef enum logic [1:0] {
    RegInvert = 2'd0,
    RegFlip   = 2'd1,
    RegSwap   = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    SlotInv,
    SlotAccCmd,
    SlotAccVal,
    SlotCol,
    SlotXsHi,
    SlotXsLo,
    SlotXeHi,
    SlotXeLo,
    SlotRow,
    SlotYsHi,
    SlotYsLo,
    SlotYeHi,
    SlotYeLo,
    SlotWrite,
    SlotPixR,
    SlotPixG,
    SlotPixB
  } slot_e;

  typedef struct packed {
    logic                need_acc;
    logic                inv_val;
    logic [7:0]          mode;
    logic [InCoordW-1:0] x_start;
    logic [InCoordW-1:0] x_end;
    logic [InCoordW-1:0] y_start;
    logic [InCoordW-1:0] y_end;
    logic [15:0]         pixel_rgb565;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } obyte_t;

  function automatic logic [15:0] coord_word(input logic [InCoordW-1:0] c);
    coord_word = 16'(c) & CoordMask;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/panel_window_pixel_byte_formatter.sv =====
// ----------------------------------------------------------------------------
// panel_window_pixel_byte_formatter: LCD command and pixel byte stream
// Windows: changed invert/access, then address commands. Pixels: three RGB666 bytes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  s_axis  | in  | tvalid/tready        | tdata window or pixel, tuser kind
//  m_axis  | out | tvalid/tready        | tdata byte, tuser data flag, tlast
//  cfg     | in  | cfg_valid/cfg_ready  | index 2 bits, data 1 bit
//
//  One byte per cycle while m_axis does not stall: a pixel is three bytes, a
//  window 11 to 14, through the single byte-wide output register. The next
//  word is taken in the cycle the last byte of the current one moves to the
//  output register. Reset clears settings and both valid flags and sets sent
//  state to match. A stall on m_axis holds the output register and the held word.
// ----------------------------------------------------------------------------
`default_nettype none

module panel_window_pixel_byte_formatter import pwpbf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // x_start[9:0], x_end[19:10], y_start[29:20], y_end[39:30], pixel_rgb565[55:40]
  input  wire logic [55:0] s_axis_tdata,
  // req_type[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]       m_axis_tdata,
  // is_data[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic        cfg_data_i
);

  logic   invert_q, flip_q, swap_q;
  logic   sent_inv_q;
  logic [7:0] sent_mode_q;
  logic   hold_valid_q;
  item_t  item_q, item_d;
  slot_e  slot_q, slot_d;
  logic   out_valid_q;
  obyte_t out_q;

  obyte_t gen_byte;
  slot_e  gen_next;
  logic   advance, s_fire;
  logic [7:0] mode_now;
  logic   need_inv, need_acc;

  pwpbf_byte_gen u_gen (
    .item_i      (item_q),
    .slot_i      (slot_q),
    .byte_o      (gen_byte),
    .next_slot_o (gen_next)
  );

  assign cfg_ready_o   = 1'b1;
  assign advance       = hold_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !hold_valid_q || (advance && gen_byte.last);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign mode_now = (flip_q ? AccessFlip : AccessBase) ^ (swap_q ? AccessBgr : 8'h00);
  assign need_inv = invert_q != sent_inv_q;
  assign need_acc = mode_now != sent_mode_q;

  always_comb begin
    item_d = '{need_acc:     need_acc,
               inv_val:      invert_q,
               mode:         mode_now,
               x_start:      s_axis_tdata[9:0],
               x_end:        s_axis_tdata[19:10],
               y_start:      s_axis_tdata[29:20],
               y_end:        s_axis_tdata[39:30],
               pixel_rgb565: s_axis_tdata[55:40]};
    if (s_axis_tuser) begin
      slot_d = SlotPixR;
    end else if (need_inv) begin
      slot_d = SlotInv;
    end else if (need_acc) begin
      slot_d = SlotAccCmd;
    end else begin
      slot_d = SlotCol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      flip_q   <= 1'b0;
      swap_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegInvert: invert_q <= cfg_data_i;
        RegFlip:   flip_q   <= cfg_data_i;
        RegSwap:   swap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_inv_q  <= 1'b0;
      sent_mode_q <= AccessBase;
    end else if (s_fire && !s_axis_tuser) begin
      sent_inv_q  <= invert_q;
      sent_mode_q <= mode_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      slot_q       <= SlotInv;
    end else if (s_fire) begin
      hold_valid_q <= 1'b1;
      slot_q       <= slot_d;
    end else if (advance) begin
      hold_valid_q <= !gen_byte.last;
      slot_q       <= gen_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= gen_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_byte;
  assign m_axis_tuser  = out_q.is_data;
  assign m_axis_tlast  = out_q.last;

  a_pix_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser |=> hold_valid_q && slot_q == SlotPixR)
    else $error("pixel word did not start at red byte");

  a_win_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata == CmdWrite)
    else $error("window sequence did not end with memory write");

  a_pix_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser |-> m_axis_tdata[2:0] == 3'b000)
    else $error("pixel last byte not left aligned");

  a_sent_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !s_axis_tuser |=> sent_inv_q == invert_q && sent_mode_q == mode_now)
    else $error("sent state not updated on window start");

endmodule

`default_nettype wire

// ===== hdl/pwpbf_byte_gen.sv =====
// ----------------------------------------------------------------------------
// pwpbf_byte_gen: byte selector
// Picks the byte of the held item for the current slot and the slot after it.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpbf_byte_gen import pwpbf_pkg::*; (
  input  item_t  item_i,
  input  slot_e  slot_i,
  output obyte_t byte_o,
  output slot_e  next_slot_o
);

  logic [15:0] xs, xe, ys, ye;

  assign xs = coord_word(item_i.x_start);
  assign xe = coord_word(item_i.x_end);
  assign ys = coord_word(item_i.y_start);
  assign ye = coord_word(item_i.y_end);

  always_comb begin
    byte_o      = '{out_byte: CmdWrite, is_data: 1'b0, last: 1'b1};
    next_slot_o = SlotInv;
    case (slot_i)
      SlotInv: begin
        byte_o.out_byte = item_i.inv_val ? CmdInvOn : CmdInvOff;
        byte_o.last     = 1'b0;
        next_slot_o     = item_i.need_acc ? SlotAccCmd : SlotCol;
      end
      SlotAccCmd: begin
        byte_o.out_byte = CmdAccess;
        byte_o.last     = 1'b0;
        next_slot_o     = SlotAccVal;
      end
      SlotAccVal: begin
        byte_o      = '{out_byte: item_i.mode, is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotCol;
      end
      SlotCol: begin
        byte_o.out_byte = CmdColumn;
        byte_o.last     = 1'b0;
        next_slot_o     = SlotXsHi;
      end
      SlotXsHi: begin
        byte_o      = '{out_byte: xs[15:8], is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotXsLo;
      end
      SlotXsLo: begin
        byte_o      = '{out_byte: xs[7:0], is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotXeHi;
      end
      SlotXeHi: begin
        byte_o      = '{out_byte: xe[15:8], is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotXeLo;
      end
      SlotXeLo: begin
        byte_o      = '{out_byte: xe[7:0], is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotRow;
      end
      SlotRow: begin
        byte_o.out_byte = CmdRow;
        byte_o.last     = 1'b0;
        next_slot_o     = SlotYsHi;
      end
      SlotYsHi: begin
        byte_o      = '{out_byte: ys[15:8], is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotYsLo;
      end
      SlotYsLo: begin
        byte_o      = '{out_byte: ys[7:0], is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotYeHi;
      end
      SlotYeHi: begin
        byte_o      = '{out_byte: ye[15:8], is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotYeLo;
      end
      SlotYeLo: begin
        byte_o      = '{out_byte: ye[7:0], is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotWrite;
      end
      SlotWrite: begin
        byte_o.out_byte = CmdWrite;
      end
      SlotPixR: begin
        byte_o      = '{out_byte: {item_i.pixel_rgb565[15:11], 3'b000},
                        is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotPixG;
      end
      SlotPixG: begin
        byte_o      = '{out_byte: {item_i.pixel_rgb565[10:5], 2'b00},
                        is_data: 1'b1, last: 1'b0};
        next_slot_o = SlotPixB;
      end
      SlotPixB: begin
        byte_o = '{out_byte: {item_i.pixel_rgb565[4:0], 3'b000},
                   is_data: 1'b1, last: 1'b1};
      end
      default: begin
        byte_o.out_byte = CmdWrite;
      end
    endcase
  end

endmodule

`default_nettype wire
